// ===== sv/incremental_pid_step_target_core_macros.svh =====
// Assertion macros shared by the step target core.
`ifndef INCREMENTAL_PID_STEP_TARGET_CORE_MACROS_SVH
`define INCREMENTAL_PID_STEP_TARGET_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define IPST_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define IPST_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/ipst_pkg.sv =====
// Types and constants of the incremental PID step target core.
package ipst_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 16;
	localparam int POS_W      = 16;
	localparam int ERR_W      = 17;
	localparam int LIMIT_W    = 15;
	localparam int ACC_W      = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP_Y       = 3'd0,
		CFG_KI_Y       = 3'd1,
		CFG_KD_Y       = 3'd2,
		CFG_KP_X       = 3'd3,
		CFG_KI_X       = 3'd4,
		CFG_KD_X       = 3'd5,
		CFG_STEP_LIMIT = 3'd6
	} cfg_idx_t;

	typedef logic [1:0] dir_t;

	localparam dir_t DIR_HOLD = 2'd0;
	localparam dir_t DIR_CCW  = 2'd1;
	localparam dir_t DIR_CW   = 2'd2;

	localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 15'd350;

endpackage

// ===== sv/incremental_pid_step_target_core.sv =====
// A word taken into stage one moves through stages two, three and four to the output.
// Throughput: one word per cycle while the output is not stalled; a four-stage pipeline with per-stage stall.
// Error history is read and written in stage one, the step accumulator in stage three,
// so words for the same axis may follow each other in back-to-back cycles.
// Reset clears the gains, the error history, the accumulators and all valid flags;
// step_limit resets to 350.
`include "incremental_pid_step_target_core_macros.svh"

module incremental_pid_step_target_core #(
	parameter int FRAC_BITS = 8,
	parameter int AXES      = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [ipst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ipst_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 axis,
	input  logic signed [ipst_pkg::POS_W-1:0]    target_pos,
	input  logic signed [ipst_pkg::POS_W-1:0]    measured_pos,
	input  logic signed [ipst_pkg::POS_W-1:0]    step_position,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ipst_pkg::ACC_W-1:0]    pid_increment,
	output logic signed [ipst_pkg::POS_W-1:0]    step_target,
	output ipst_pkg::dir_t                       direction,
	output logic                                 start_pulses
);
	import ipst_pkg::*;

	localparam int DP_W  = ERR_W + 1;
	localparam int DD_W  = ERR_W + 2;
	localparam int PP_W  = GAIN_W + DP_W;
	localparam int PI_W  = GAIN_W + ERR_W;
	localparam int PD_W  = GAIN_W + DD_W;
	localparam int SUM_W = PD_W + 2;
	localparam logic signed [SUM_W-1:0] BIAS =
		SUM_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
	localparam logic [AXES > 1 ? 0 : 0:0] LAST_AXIS = 1'(AXES - 1);

	// configuration registers
	logic signed [GAIN_W-1:0]  kp_q [2];
	logic signed [GAIN_W-1:0]  ki_q [2];
	logic signed [GAIN_W-1:0]  kd_q [2];
	logic        [LIMIT_W-1:0] limit_q;

	// per-axis state
	logic signed [ERR_W-1:0] err1_q [AXES];
	logic signed [ERR_W-1:0] err2_q [AXES];
	logic signed [ACC_W-1:0] acc_q  [AXES];

	// pipeline valids and advances
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	// stage registers
	logic                    ax_s1, ax_s2, ax_s3;
	logic signed [POS_W-1:0] tgt_s1, meas_s1;
	logic signed [POS_W-1:0] spos_s1, spos_s2, spos_s3;
	logic signed [PP_W-1:0]  pp_s2;
	logic signed [PI_W-1:0]  pi_s2;
	logic signed [PD_W-1:0]  pd_s2;
	logic signed [ACC_W-1:0] inc_s3, inc_s4;
	logic signed [POS_W-1:0] tgt_s4;
	dir_t                    dir_s4;

	// stage one combinational
	logic                    ax1;
	logic signed [ERR_W-1:0] e_c, e1_c, e2_c;
	logic signed [DP_W-1:0]  dp_c;
	logic signed [DD_W-1:0]  dd_c;
	logic signed [PP_W-1:0]  pp_c;
	logic signed [PI_W-1:0]  pi_c;
	logic signed [PD_W-1:0]  pd_c;

	// stage two combinational
	logic signed [SUM_W-1:0] sum_c, bsum_c, shr_c;
	logic signed [ACC_W-1:0] inc_c;

	// stage three combinational
	logic signed [ACC_W:0]   asum_c;
	logic signed [ACC_W-1:0] acc_new_c;
	logic signed [ACC_W-1:0] lim_c;
	logic signed [POS_W-1:0] clamp_c;
	dir_t                    dir_c;

	// advance a stage when the one after it is empty or moving
	assign adv4     = v_s4 && !out_stall;
	assign adv3     = v_s3 && (!v_s4 || adv4);
	assign adv2     = v_s2 && (!v_s3 || adv3);
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign in_stall = v_s1 && !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (!v_s2 || adv2) v_s2 <= adv1;
			if (!v_s3 || adv3) v_s3 <= adv2;
			if (!v_s4 || adv4) v_s4 <= adv3;
		end
	end

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '{default: '0};
			ki_q    <= '{default: '0};
			kd_q    <= '{default: '0};
			limit_q <= STEP_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KP_Y:       kp_q[0] <= cfg_data;
				CFG_KI_Y:       ki_q[0] <= cfg_data;
				CFG_KD_Y:       kd_q[0] <= cfg_data;
				CFG_KP_X:       kp_q[1] <= cfg_data;
				CFG_KI_X:       ki_q[1] <= cfg_data;
				CFG_KD_X:       kd_q[1] <= cfg_data;
				CFG_STEP_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the input word
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ax_s1   <= axis;
			tgt_s1  <= target_pos;
			meas_s1 <= measured_pos;
			spos_s1 <= step_position;
		end
	end

	// stage one: error, differences and the three gain products
	always_comb begin
		ax1  = (AXES > 1) ? ax_s1 : LAST_AXIS;
		e_c  = {tgt_s1[POS_W-1], tgt_s1} - {meas_s1[POS_W-1], meas_s1};
		e1_c = err1_q[ax1];
		e2_c = err2_q[ax1];
		dp_c = {e_c[ERR_W-1], e_c} - {e1_c[ERR_W-1], e1_c};
		dd_c = {{2{e_c[ERR_W-1]}}, e_c} - {e1_c[ERR_W-1], e1_c, 1'b0}
			+ {{2{e2_c[ERR_W-1]}}, e2_c};
		pp_c = kp_q[ax1] * dp_c;
		pi_c = ki_q[ax1] * e_c;
		pd_c = kd_q[ax1] * dd_c;
	end

	// shift the error history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err1_q <= '{default: '0};
			err2_q <= '{default: '0};
		end else if (adv1) begin
			err1_q[ax1] <= e_c;
			err2_q[ax1] <= e1_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ax_s2   <= ax1;
			spos_s2 <= spos_s1;
			pp_s2   <= pp_c;
			pi_s2   <= pi_c;
			pd_s2   <= pd_c;
		end
	end

	// stage two: sum, truncate toward zero, saturate to 32 bits
	always_comb begin
		sum_c  = SUM_W'(pp_s2) + SUM_W'(pi_s2) + SUM_W'(pd_s2);
		bsum_c = sum_c[SUM_W-1] ? sum_c + BIAS : sum_c;
		shr_c  = bsum_c >>> FRAC_BITS;
		if (shr_c[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){shr_c[SUM_W-1]}}) begin
			inc_c = shr_c[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			inc_c = shr_c[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			ax_s3   <= ax_s2;
			spos_s3 <= spos_s2;
			inc_s3  <= inc_c;
		end
	end

	// stage three: saturating accumulate, clamp, direction
	always_comb begin
		asum_c = {acc_q[ax_s3][ACC_W-1], acc_q[ax_s3]} + {inc_s3[ACC_W-1], inc_s3};
		if (asum_c[ACC_W] != asum_c[ACC_W-1]) begin
			acc_new_c = asum_c[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_new_c = asum_c[ACC_W-1:0];
		end
		lim_c = {{(ACC_W-LIMIT_W){1'b0}}, limit_q};
		if (acc_new_c >= lim_c) begin
			clamp_c = POS_W'(lim_c);
		end else if (acc_new_c <= -lim_c) begin
			clamp_c = POS_W'(-lim_c);
		end else begin
			clamp_c = acc_new_c[POS_W-1:0];
		end
		if (clamp_c < spos_s3) begin
			dir_c = DIR_CCW;
		end else if (clamp_c > spos_s3) begin
			dir_c = DIR_CW;
		end else begin
			dir_c = DIR_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '{default: '0};
		end else if (adv3) begin
			acc_q[ax_s3] <= acc_new_c;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv3) begin
			inc_s4 <= inc_s3;
			tgt_s4 <= clamp_c;
			dir_s4 <= dir_c;
		end
	end

	assign out_valid     = v_s4;
	assign pid_increment = inc_s4;
	assign step_target   = tgt_s4;
	assign direction     = dir_s4;
	assign start_pulses  = (dir_s4 != DIR_HOLD);

	`IPST_ASSERT_SAME(a_stall_needs_word, clk, arst_n, in_stall, v_s1, "stall with empty stage one")
	`IPST_ASSERT_SAME(a_no_overwrite, clk, arst_n, v_s4 && out_stall, !adv3, "output overwritten while stalled")
	`IPST_ASSERT_SAME(a_target_in_limit, clk, arst_n, out_valid, (ACC_W'(step_target) <= lim_c) && (ACC_W'(step_target) >= -lim_c), "step target outside limit")
	`IPST_ASSERT_NEXT(a_s3_moves_on, clk, arst_n, adv3, v_s4, "stage three word lost")

endmodule
